FILE: design/ogg_page_stream_checker_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Ogg page stream checker
// Concurrent assertion wrappers on clk, with and without the rst disable.
// ---------------------------------------------------------------------------
`ifndef OGG_PAGE_STREAM_CHECKER_CORE_MACROS_SVH
`define OGG_PAGE_STREAM_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge outside reset.
`define OPSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ogg page stream checker assertion failed");

// Checked at every rising edge, reset included.
`define OPSC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ogg page stream checker assertion failed");

`else

`define OPSC_ASSERT(label, prop)
`define OPSC_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: design/ogg_psc_pkg.sv
// ---------------------------------------------------------------------------
// Ogg page stream checker package
// Status codes, Ogg framing constants and the byte-wide CRC-32 update.
// ---------------------------------------------------------------------------
package ogg_psc_pkg;

  localparam logic [3:0] ST_IN_PAGE  = 4'd0;
  localparam logic [3:0] ST_PAGE_OK  = 4'd1;
  localparam logic [3:0] ST_END_OK   = 4'd2;
  localparam logic [3:0] ST_MAGIC    = 4'd3;
  localparam logic [3:0] ST_VERSION  = 4'd4;
  localparam logic [3:0] ST_CRC      = 4'd5;
  localparam logic [3:0] ST_SERIAL   = 4'd6;
  localparam logic [3:0] ST_SEQUENCE = 4'd7;
  localparam logic [3:0] ST_STOPPED  = 4'd8;

  // "OggS" read as a little-endian word.
  localparam logic [31:0] OGG_MAGIC = 32'h5367674F;
  localparam logic [7:0]  EOS_MASK  = 8'h04;
  localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;

  // Header byte positions.
  localparam logic [4:0] IDX_MAGIC_LAST = 5'd3;
  localparam logic [4:0] IDX_VERSION    = 5'd4;
  localparam logic [4:0] IDX_TYPE       = 5'd5;
  localparam logic [4:0] IDX_SERIAL     = 5'd14;
  localparam logic [4:0] IDX_SEQUENCE   = 5'd18;
  localparam logic [4:0] IDX_CHECKSUM   = 5'd22;
  localparam logic [4:0] IDX_SEG_COUNT  = 5'd26;

  // One byte through the CRC, MSB first, eight shift steps.
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  // Replace byte lane 'lane' of a little-endian word.
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[{lane, 3'b000} +: 8] = b;
    return w;
  endfunction

endpackage

FILE: design/ogg_psc_if.sv
// ---------------------------------------------------------------------------
// Ogg page stream checker channels
// Valid/ready channels for the input byte stream and the per-byte result.
// ---------------------------------------------------------------------------
interface ogg_psc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ogg_psc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        page_end;
  logic [31:0] serial_number;
  logic [31:0] sequence_number;

  modport source (output valid, output status, output page_end, output serial_number,
                  output sequence_number, input ready);
  modport sink (input valid, input status, input page_end, input serial_number,
                input sequence_number, output ready);
endinterface

FILE: design/ogg_page_stream_checker_core.sv
// ---------------------------------------------------------------------------
// Ogg page stream checker
// Parses Ogg pages byte by byte, checks framing, CRC, serial and sequence.
// ---------------------------------------------------------------------------
// The checker takes one byte of an Ogg stream per clock cycle and returns
// one result for every byte, registered in the cycle after the byte's transfer. Each
// result carries a status code, a page end flag and the serial and sequence
// numbers of the current page as received so far. The whole update for one
// byte (header field capture, segment table sum, payload countdown and one
// byte of the Ogg CRC-32 as an XOR tree) sits between the parser state and a
// single result register, so a byte can be taken in every cycle. The result
// register is refilled in the same cycle in which its contents are taken, so
// the input stalls only while a finished result is held back by the sink.
// After a bad page or a good end-of-stream page every further byte reports
// "stopped" until reset.
// ---------------------------------------------------------------------------
`include "ogg_page_stream_checker_core_macros.svh"

module ogg_page_stream_checker_core
  import ogg_psc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ogg_psc_in_if.sink    stream,
  ogg_psc_out_if.source result
);

  // Parser phase within a page.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SEGMENTS,
    PH_PAYLOAD
  } phase_t;

  // Parser state.
  phase_t      phase, phase_next;
  logic [4:0]  header_idx, header_idx_next;
  logic [7:0]  segments_left, segments_left_next;
  logic [15:0] payload_left, payload_left_next;
  logic [31:0] running_crc, running_crc_next;
  logic        page_eos, page_eos_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic [31:0] serial_now, serial_now_next;
  logic [31:0] sequence_now, sequence_now_next;
  logic [31:0] serial_prev, serial_prev_next;
  logic [31:0] sequence_prev, sequence_prev_next;
  logic        have_prev, have_prev_next;
  logic        stopped, stopped_next;

  // Result register.
  logic        out_valid;
  logic [3:0]  status_reg;
  logic        page_end_reg;
  logic [31:0] serial_reg;
  logic [31:0] sequence_reg;

  // Per-byte combinational results.
  logic [7:0]  b;
  logic        accept;
  logic        in_checksum;
  logic [31:0] crc_base;
  logic [7:0]  crc_byte;
  logic [31:0] crc_new;
  logic [15:0] payload_sum;
  logic [15:0] payload_dec;
  logic [7:0]  segments_dec;
  logic        finish;
  logic [3:0]  status_calc;
  logic        page_end_calc;

  // Result properties used by the checks below.
  logic        page_verdict;
  logic        stopped_out;

  assign b = stream.data_byte;

  // The result register can take a new byte whenever it is empty or its
  // current contents leave in this cycle.
  assign stream.ready = !out_valid || result.ready;
  assign accept       = stream.valid && stream.ready;

  // The four checksum bytes enter the CRC as zero; a new page restarts it.
  assign in_checksum  = (phase == PH_HEADER) && (header_idx >= IDX_CHECKSUM) &&
                        (header_idx < IDX_SEG_COUNT);
  assign crc_base     = ((phase == PH_HEADER) && (header_idx == 5'd0)) ? 32'd0 : running_crc;
  assign crc_byte     = in_checksum ? 8'd0 : b;
  assign crc_new      = crc_feed(crc_base, crc_byte);

  assign payload_sum  = payload_left + {8'd0, b};
  assign payload_dec  = payload_left - 16'd1;
  assign segments_dec = segments_left - 8'd1;

  always_comb begin
    phase_next         = phase;
    header_idx_next    = header_idx;
    segments_left_next = segments_left;
    payload_left_next  = payload_left;
    running_crc_next   = running_crc;
    page_eos_next      = page_eos;
    stored_crc_next    = stored_crc;
    serial_now_next    = serial_now;
    sequence_now_next  = sequence_now;
    serial_prev_next   = serial_prev;
    sequence_prev_next = sequence_prev;
    have_prev_next     = have_prev;
    stopped_next       = stopped;
    status_calc        = ST_IN_PAGE;
    page_end_calc      = 1'b0;
    finish             = 1'b0;

    if (stopped) begin
      status_calc = ST_STOPPED;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          running_crc_next = crc_new;
          if (header_idx == 5'd0) begin
            serial_now_next   = 32'd0;
            sequence_now_next = 32'd0;
          end
          // Bytes 0 to 3 collect the magic word in the checksum register,
          // which the real checksum overwrites later in the header.
          if (header_idx <= IDX_MAGIC_LAST) begin
            stored_crc_next = put_byte(stored_crc, header_idx[1:0], b);
            if ((header_idx == IDX_MAGIC_LAST) && (stored_crc_next != OGG_MAGIC)) begin
              status_calc  = ST_MAGIC;
              stopped_next = 1'b1;
            end
          end else if (header_idx == IDX_VERSION) begin
            if (b != 8'd0) begin
              status_calc  = ST_VERSION;
              stopped_next = 1'b1;
            end
          end else if (header_idx == IDX_TYPE) begin
            page_eos_next = |(b & EOS_MASK);
          end else if ((header_idx >= IDX_SERIAL) && (header_idx < IDX_SEQUENCE)) begin
            serial_now_next = put_byte(serial_now_next, 2'(header_idx - IDX_SERIAL), b);
          end else if ((header_idx >= IDX_SEQUENCE) && (header_idx < IDX_CHECKSUM)) begin
            sequence_now_next = put_byte(sequence_now_next, 2'(header_idx - IDX_SEQUENCE), b);
          end else if (in_checksum) begin
            stored_crc_next = put_byte(stored_crc, 2'(header_idx - IDX_CHECKSUM), b);
          end

          if (!stopped_next) begin
            if (header_idx >= IDX_SEG_COUNT) begin
              segments_left_next = b;
              payload_left_next  = 16'd0;
              header_idx_next    = 5'd0;
              if (b == 8'd0) begin
                finish = 1'b1;
              end else begin
                phase_next = PH_SEGMENTS;
              end
            end else begin
              header_idx_next = header_idx + 5'd1;
            end
          end
        end

        PH_SEGMENTS: begin
          running_crc_next   = crc_new;
          payload_left_next  = payload_sum;
          segments_left_next = segments_dec;
          if (segments_dec == 8'd0) begin
            if (payload_sum == 16'd0) begin
              finish = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end

        PH_PAYLOAD: begin
          running_crc_next  = crc_new;
          payload_left_next = payload_dec;
          if (payload_dec == 16'd0) begin
            finish = 1'b1;
          end
        end

        default: begin
          phase_next = PH_HEADER;
        end
      endcase

      // Page end: CRC first, then serial, then sequence.
      if (finish) begin
        page_end_calc = 1'b1;
        priority if (running_crc_next != stored_crc_next) begin
          status_calc = ST_CRC;
        end else if (have_prev && (serial_now_next != serial_prev)) begin
          status_calc = ST_SERIAL;
        end else if (have_prev && (sequence_now_next != sequence_prev + 32'd1)) begin
          status_calc = ST_SEQUENCE;
        end else begin
          serial_prev_next   = serial_now_next;
          sequence_prev_next = sequence_now_next;
          have_prev_next     = 1'b1;
          status_calc        = page_eos_next ? ST_END_OK : ST_PAGE_OK;
        end
        if (status_calc != ST_PAGE_OK) begin
          stopped_next = 1'b1;
        end
        phase_next         = PH_HEADER;
        header_idx_next    = 5'd0;
        segments_left_next = 8'd0;
        payload_left_next  = 16'd0;
        running_crc_next   = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_idx    <= 5'd0;
      segments_left <= 8'd0;
      payload_left  <= 16'd0;
      running_crc   <= 32'd0;
      page_eos      <= 1'b0;
      stored_crc    <= 32'd0;
      serial_now    <= 32'd0;
      sequence_now  <= 32'd0;
      serial_prev   <= 32'd0;
      sequence_prev <= 32'd0;
      have_prev     <= 1'b0;
      stopped       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        header_idx    <= header_idx_next;
        segments_left <= segments_left_next;
        payload_left  <= payload_left_next;
        running_crc   <= running_crc_next;
        page_eos      <= page_eos_next;
        stored_crc    <= stored_crc_next;
        serial_now    <= serial_now_next;
        sequence_now  <= sequence_now_next;
        serial_prev   <= serial_prev_next;
        sequence_prev <= sequence_prev_next;
        have_prev     <= have_prev_next;
        stopped       <= stopped_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_reg   <= status_calc;
      page_end_reg <= page_end_calc;
      serial_reg   <= serial_now_next;
      sequence_reg <= sequence_now_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.status          = status_reg;
  assign result.page_end        = page_end_reg;
  assign result.serial_number   = serial_reg;
  assign result.sequence_number = sequence_reg;

  assign page_verdict = (status_reg == ST_PAGE_OK) || (status_reg == ST_END_OK) ||
                        (status_reg == ST_CRC) || (status_reg == ST_SERIAL) ||
                        (status_reg == ST_SEQUENCE);
  assign stopped_out  = out_valid && (status_reg == ST_STOPPED) && !page_end_reg;

  // A page end only ever reports a page verdict, never an in-page or stop code.
  `OPSC_ASSERT(a_page_end_verdict, (result.valid && result.page_end) |-> page_verdict)

  // Once stopped, the checker stays stopped until reset.
  `OPSC_ASSERT(a_stop_sticky, stopped |=> stopped)

  // A byte taken while stopped yields a stopped result without a page end.
  `OPSC_ASSERT(a_stopped_result, (stopped && accept) |=> stopped_out)

  // The payload count is only live after the segment table has started.
  `OPSC_ASSERT_ALWAYS(a_header_no_payload, (phase == PH_HEADER) |-> (payload_left == 16'd0))

endmodule
